// File: rtl/core/polar_point_distance_macros.svh
// assertion helpers, clocked on clk and held off during reset
`ifndef POLAR_POINT_DISTANCE_MACROS_SVH
`define POLAR_POINT_DISTANCE_MACROS_SVH

// same-cycle implication
`define PPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ppd_pkg.sv
package ppd_pkg;

	localparam int ANGLE_W        = 17;
	localparam int SEP_W          = 26;
	localparam int RADIUS_BITS_DEF = 24;
	localparam int ANGLE_FRAC_DEF = 8;

	// rounded sine and cosine magnitudes, 0..65536
	localparam int TRIG_W      = 17;

	localparam int CORDIC_N    = 48;
	localparam int CORDIC_FRAC = 48;
	localparam int CORDIC_XY_W = CORDIC_FRAC + 2;
	// extra fraction bits below the angle lsb in the residual angle
	localparam int ZGUARD      = 40;

	localparam int ANG_LAT   = CORDIC_N + 4;
	localparam int COORD_LAT = 2;
	localparam int DIST_LAT  = 3;
	localparam int SQRT_N    = 32;
	localparam int SQ_IN_W   = 2 * SQRT_N;

	localparam real PI_R        = 3.14159265358979323846;
	localparam real DEG_PER_RAD = 180.0 / PI_R;

	typedef struct packed {
		logic [TRIG_W-1:0] sin_mag;
		logic              sin_neg;
		logic [TRIG_W-1:0] cos_mag;
		logic              cos_neg;
	} ppd_trig_t;

	// atan(2^-idx) in degrees, scaled by 2^(frac + ZGUARD)
	function automatic logic [63:0] cordic_atan(input int idx, input int frac);
		real v;
		v = $atan($pow(2.0, -1.0 * idx)) * DEG_PER_RAD * $pow(2.0, 1.0 * (frac + ZGUARD));
		return 64'(longint'(v));
	endfunction

	// start vector length, pre-scaled by the inverse rotation gain
	function automatic logic [63:0] cordic_gain();
		real k;
		k = 1.0;
		for (int i = 0; i < CORDIC_N; i++)
			k = k * $pow(1.0 + $pow(2.0, -2.0 * i), -0.5);
		return 64'(longint'(k * $pow(2.0, 1.0 * CORDIC_FRAC)));
	endfunction

endpackage

// File: rtl/core/ppd_in_if.sv
interface ppd_in_if #(
	parameter int RADIUS_BITS = ppd_pkg::RADIUS_BITS_DEF
);
	logic                                valid;
	logic                                ready;
	logic signed [ppd_pkg::ANGLE_W-1:0]  from_elevation;
	logic signed [ppd_pkg::ANGLE_W-1:0]  from_azimuth;
	logic        [RADIUS_BITS-1:0]       from_radius;
	logic signed [ppd_pkg::ANGLE_W-1:0]  to_elevation;
	logic signed [ppd_pkg::ANGLE_W-1:0]  to_azimuth;
	logic        [RADIUS_BITS-1:0]       to_radius;

	modport source (
		output valid, from_elevation, from_azimuth, from_radius,
		output to_elevation, to_azimuth, to_radius,
		input  ready
	);

	modport sink (
		input  valid, from_elevation, from_azimuth, from_radius,
		input  to_elevation, to_azimuth, to_radius,
		output ready
	);
endinterface

// File: rtl/core/ppd_out_if.sv
interface ppd_out_if;
	logic                       valid;
	logic                       ready;
	logic [ppd_pkg::SEP_W-1:0]  separation;

	modport source (
		output valid, separation,
		input  ready
	);

	modport sink (
		input  valid, separation,
		output ready
	);
endinterface

// File: rtl/core/ppd_cordic_cell.sv
module ppd_cordic_cell #(
	parameter int IDX             = 0,
	parameter int ANGLE_FRAC_BITS = ppd_pkg::ANGLE_FRAC_DEF
) (
	input  logic                                                    clk,
	input  logic                                                    en,
	input  logic signed [ppd_pkg::CORDIC_XY_W-1:0]                  x_in,
	input  logic signed [ppd_pkg::CORDIC_XY_W-1:0]                  y_in,
	input  logic signed [ppd_pkg::ZGUARD+ANGLE_FRAC_BITS+7:0]       z_in,
	output logic signed [ppd_pkg::CORDIC_XY_W-1:0]                  x_out,
	output logic signed [ppd_pkg::CORDIC_XY_W-1:0]                  y_out,
	output logic signed [ppd_pkg::ZGUARD+ANGLE_FRAC_BITS+7:0]       z_out
);
	import ppd_pkg::*;

	localparam int Z_W = ZGUARD + ANGLE_FRAC_BITS + 8;
	localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(cordic_atan(IDX, ANGLE_FRAC_BITS));

	logic signed [CORDIC_XY_W-1:0] x_sh;
	logic signed [CORDIC_XY_W-1:0] y_sh;
	logic signed [CORDIC_XY_W-1:0] x_s1;
	logic signed [CORDIC_XY_W-1:0] y_s1;
	logic signed [Z_W-1:0]         z_s1;

	assign x_sh = x_in >>> IDX;
	assign y_sh = y_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_in[Z_W-1]) begin
				// overshot: rotate back
				x_s1 <= x_in + y_sh;
				y_s1 <= y_in - x_sh;
				z_s1 <= z_in + ATAN_I;
			end else begin
				x_s1 <= x_in - y_sh;
				y_s1 <= y_in + x_sh;
				z_s1 <= z_in - ATAN_I;
			end
		end
	end

	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;
endmodule

// File: rtl/core/ppd_angle_unit.sv
module ppd_angle_unit #(
	parameter int ANGLE_FRAC_BITS = ppd_pkg::ANGLE_FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [ppd_pkg::ANGLE_W-1:0] angle,
	output ppd_pkg::ppd_trig_t                 trig
);
	import ppd_pkg::*;

	localparam int F            = ANGLE_FRAC_BITS;
	localparam int FULL_TURN    = 360 << F;
	localparam int QUARTER_TURN = 90 << F;
	localparam int ANG_SPAN     = 1 << (ANGLE_W - 1);
	// whole turns added so that the dividend is never negative
	localparam int OFFSET       = FULL_TURN * ((ANG_SPAN + FULL_TURN - 1) / FULL_TURN);
	localparam int U_W          = $clog2(OFFSET + ANG_SPAN);
	localparam int SH           = 2 * U_W;
	localparam longint RECIP    = ((longint'(1) << SH) + FULL_TURN - 1) / FULL_TURN;
	localparam int M_W          = $clog2(RECIP + 1);
	localparam int P_W          = U_W + M_W;
	localparam int Q_W          = P_W - SH;
	localparam int A_W          = $clog2(FULL_TURN);
	localparam int R_W          = $clog2(QUARTER_TURN + 1);
	localparam int Z_W          = ZGUARD + F + 8;
	localparam int RND_SH       = CORDIC_FRAC - (TRIG_W - 1);
	localparam logic signed [CORDIC_XY_W-1:0] GAIN = CORDIC_XY_W'(cordic_gain());
	localparam logic [CORDIC_XY_W:0] RND_HALF =
		{{(CORDIC_XY_W - RND_SH + 1){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};

	logic [U_W-1:0]  u;
	logic [U_W-1:0]  u_s1;
	logic [P_W-1:0]  prod_s1;
	logic [Q_W-1:0]  q;
	logic [A_W-1:0]  a_s2;
	logic [1:0]      quad;
	logic [A_W-1:0]  rem_full;
	logic [R_W-1:0]  rem;
	logic [1:0]      quad_s3;
	logic [R_W-1:0]  rem_s3;

	logic signed [CORDIC_XY_W-1:0] x_c [CORDIC_N+1];
	logic signed [CORDIC_XY_W-1:0] y_c [CORDIC_N+1];
	logic signed [Z_W-1:0]         z_c [CORDIC_N+1];
	logic [1:0]                    quad_q [CORDIC_N];

	logic [CORDIC_XY_W:0] xr;
	logic [CORDIC_XY_W:0] yr;
	logic [TRIG_W-1:0]    sin_r;
	logic [TRIG_W-1:0]    cos_r;
	ppd_trig_t            trig_s4;

	assign u = U_W'(int'(angle) + OFFSET);

	// modulo one turn by reciprocal multiply, exact over the dividend range
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= u;
			prod_s1 <= P_W'(u) * P_W'(RECIP);
		end
	end

	assign q = prod_s1[P_W-1:SH];

	always_ff @(posedge clk) begin
		if (en)
			a_s2 <= A_W'(u_s1 - U_W'(U_W'(q) * U_W'(FULL_TURN)));
	end

	always_comb begin
		if (a_s2 >= A_W'(3 * QUARTER_TURN)) begin
			quad     = 2'd3;
			rem_full = a_s2 - A_W'(3 * QUARTER_TURN);
		end else if (a_s2 >= A_W'(2 * QUARTER_TURN)) begin
			quad     = 2'd2;
			rem_full = a_s2 - A_W'(2 * QUARTER_TURN);
		end else if (a_s2 >= A_W'(QUARTER_TURN)) begin
			quad     = 2'd1;
			rem_full = a_s2 - A_W'(QUARTER_TURN);
		end else begin
			quad     = 2'd0;
			rem_full = a_s2;
		end
		// odd quadrants fold back onto the first
		if (quad[0])
			rem = R_W'(QUARTER_TURN) - rem_full[R_W-1:0];
		else
			rem = rem_full[R_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s3 <= quad;
			rem_s3  <= rem;
		end
	end

	assign x_c[0] = GAIN;
	assign y_c[0] = '0;
	assign z_c[0] = {1'b0, rem_s3, {ZGUARD{1'b0}}};

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cell
		ppd_cordic_cell #(
			.IDX             (i),
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
		) u_cell (
			.clk   (clk),
			.en    (en),
			.x_in  (x_c[i]),
			.y_in  (y_c[i]),
			.z_in  (z_c[i]),
			.x_out (x_c[i+1]),
			.y_out (y_c[i+1]),
			.z_out (z_c[i+1])
		);

		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en)
					quad_q[i] <= quad_s3;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en)
					quad_q[i] <= quad_q[i-1];
			end
		end
	end

	// round half up to 16 fraction bits, tiny negative residue reads as zero
	assign xr    = {x_c[CORDIC_N][CORDIC_XY_W-1], x_c[CORDIC_N]} + RND_HALF;
	assign yr    = {y_c[CORDIC_N][CORDIC_XY_W-1], y_c[CORDIC_N]} + RND_HALF;
	assign cos_r = xr[CORDIC_XY_W] ? '0 : xr[CORDIC_FRAC:RND_SH];
	assign sin_r = yr[CORDIC_XY_W] ? '0 : yr[CORDIC_FRAC:RND_SH];

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s4.sin_mag <= sin_r;
			trig_s4.sin_neg <= quad_q[CORDIC_N-1][1];
			trig_s4.cos_mag <= cos_r;
			trig_s4.cos_neg <= quad_q[CORDIC_N-1][0] ^ quad_q[CORDIC_N-1][1];
		end
	end

	assign trig = trig_s4;
endmodule

// File: rtl/core/ppd_coord.sv
module ppd_coord #(
	parameter int RADIUS_BITS = ppd_pkg::RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [RADIUS_BITS-1:0]        radius,
	input  ppd_pkg::ppd_trig_t            elev,
	input  ppd_pkg::ppd_trig_t            azim,
	output logic signed [RADIUS_BITS:0]   x,
	output logic signed [RADIUS_BITS:0]   y,
	output logic signed [RADIUS_BITS:0]   z
);
	import ppd_pkg::*;

	localparam int RS_W  = RADIUS_BITS + TRIG_W;
	localparam int XP_W  = RS_W + TRIG_W;
	localparam int C_W   = RADIUS_BITS + 1;
	localparam int XY_SH = 2 * (TRIG_W - 1);
	localparam int Z_SH  = TRIG_W - 1;

	logic [RS_W-1:0]        rsf_s1;
	logic [RS_W-1:0]        rcf_s1;
	logic [TRIG_W-1:0]      cq_s1;
	logic [TRIG_W-1:0]      sq_s1;
	logic                   xn_s1;
	logic                   yn_s1;
	logic                   zn_s1;
	logic [XP_W-1:0]        xp;
	logic [XP_W-1:0]        yp;
	logic [RADIUS_BITS-1:0] xm;
	logic [RADIUS_BITS-1:0] ym;
	logic [RADIUS_BITS-1:0] zm;
	logic signed [C_W-1:0]  x_s2;
	logic signed [C_W-1:0]  y_s2;
	logic signed [C_W-1:0]  z_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rsf_s1 <= RS_W'(radius) * RS_W'(elev.sin_mag);
			rcf_s1 <= RS_W'(radius) * RS_W'(elev.cos_mag);
			cq_s1  <= azim.cos_mag;
			sq_s1  <= azim.sin_mag;
			xn_s1  <= elev.sin_neg ^ azim.cos_neg;
			yn_s1  <= elev.sin_neg ^ azim.sin_neg;
			zn_s1  <= elev.cos_neg;
		end
	end

	assign xp = XP_W'(rsf_s1) * XP_W'(cq_s1);
	assign yp = XP_W'(rsf_s1) * XP_W'(sq_s1);
	assign xm = xp[XY_SH+RADIUS_BITS-1:XY_SH];
	assign ym = yp[XY_SH+RADIUS_BITS-1:XY_SH];
	assign zm = rcf_s1[Z_SH+RADIUS_BITS-1:Z_SH];

	// sign goes on after truncating the magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= xn_s1 ? -$signed(C_W'(xm)) : $signed(C_W'(xm));
			y_s2 <= yn_s1 ? -$signed(C_W'(ym)) : $signed(C_W'(ym));
			z_s2 <= zn_s1 ? -$signed(C_W'(zm)) : $signed(C_W'(zm));
		end
	end

	assign x = x_s2;
	assign y = y_s2;
	assign z = z_s2;
endmodule

// File: rtl/core/ppd_sqrt_cell.sv
module ppd_sqrt_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ppd_pkg::SQ_IN_W-1:0]   rem_in,
	input  logic [ppd_pkg::SQRT_N-1:0]    root_in,
	output logic [ppd_pkg::SQ_IN_W-1:0]   rem_out,
	output logic [ppd_pkg::SQRT_N-1:0]    root_out
);
	import ppd_pkg::*;

	localparam int T_W = SQ_IN_W + 2;

	logic [T_W-1:0]     trial;
	logic [SQ_IN_W-1:0] rem_s1;
	logic [SQRT_N-1:0]  root_s1;

	// (root + 2^i)^2 - root^2
	assign trial = (T_W'(root_in) << (IDX + 1)) + (T_W'(1) << (2 * IDX));

	always_ff @(posedge clk) begin
		if (en) begin
			if (T_W'(rem_in) >= trial) begin
				rem_s1  <= SQ_IN_W'(T_W'(rem_in) - trial);
				root_s1 <= root_in | (SQRT_N'(1) << IDX);
			end else begin
				rem_s1  <= rem_in;
				root_s1 <= root_in;
			end
		end
	end

	assign rem_out  = rem_s1;
	assign root_out = root_s1;
endmodule

// File: rtl/core/polar_point_distance.sv
// Distance between two points given as elevation, azimuth (degrees, signed, with
// ANGLE_FRAC_BITS fraction bits, any angle wraps modulo one turn) and an unsigned
// radius. Each angle runs through its own rotation chain of 48 cells to give sine
// and cosine rounded to 16 fraction bits; the points go to Cartesian form with
// coordinates truncated toward zero, and a chain of 32 root cells gives the
// truncated square root of the summed squared differences. The block takes one
// point pair every cycle unless stalled; each pair passes 90 register stages (48
// rotation cells, 32 root cells, 10 further stages) before its distance is offered
// on the output; a full output register that is not taken stalls the pipeline only
// once the word behind it arrives.
`include "polar_point_distance_macros.svh"

module polar_point_distance #(
	parameter int RADIUS_BITS     = ppd_pkg::RADIUS_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ppd_pkg::ANGLE_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ppd_in_if.sink     points,
	ppd_out_if.source  result
);
	import ppd_pkg::*;

	localparam int PIPE_LAT = ANG_LAT + COORD_LAT + DIST_LAT + SQRT_N;
	localparam int C_W      = RADIUS_BITS + 1;
	localparam int SQ_W     = 2 * C_W;
	localparam int SUM_W    = (SQ_W + 2 > SQ_IN_W) ? SQ_W + 2 : SQ_IN_W + 1;

	logic                   pipe_en;
	logic [PIPE_LAT-1:0]    vld_q;
	logic                   out_vld_q;
	logic [SEP_W-1:0]       sep_q;

	ppd_trig_t              trig_fe;
	ppd_trig_t              trig_fa;
	ppd_trig_t              trig_te;
	ppd_trig_t              trig_ta;
	logic [RADIUS_BITS-1:0] rad_from_q [ANG_LAT];
	logic [RADIUS_BITS-1:0] rad_to_q   [ANG_LAT];

	logic signed [C_W-1:0]  ca [3];
	logic signed [C_W-1:0]  cb [3];
	logic signed [C_W:0]    diff [3];
	logic [C_W-1:0]         dmag_s1 [3];
	logic [SQ_W-1:0]        sq_s2 [3];
	logic [SUM_W-1:0]       sum;
	logic [SQ_IN_W-1:0]     sum_s3;

	logic [SQ_IN_W-1:0]     rem_c  [SQRT_N+1];
	logic [SQRT_N-1:0]      root_c [SQRT_N+1];

	// only hold when a finished word waits and another is right behind it
	assign pipe_en      = !out_vld_q || result.ready || !vld_q[PIPE_LAT-1];
	assign points.ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], points.valid};
		end
	end

	ppd_angle_unit #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fe (
		.clk (clk), .en (pipe_en), .angle (points.from_elevation), .trig (trig_fe)
	);
	ppd_angle_unit #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_fa (
		.clk (clk), .en (pipe_en), .angle (points.from_azimuth), .trig (trig_fa)
	);
	ppd_angle_unit #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_te (
		.clk (clk), .en (pipe_en), .angle (points.to_elevation), .trig (trig_te)
	);
	ppd_angle_unit #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ta (
		.clk (clk), .en (pipe_en), .angle (points.to_azimuth), .trig (trig_ta)
	);

	// radii wait alongside the trig chains
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rad_from_q[0] <= points.from_radius;
			rad_to_q[0]   <= points.to_radius;
			for (int i = 1; i < ANG_LAT; i++) begin
				rad_from_q[i] <= rad_from_q[i-1];
				rad_to_q[i]   <= rad_to_q[i-1];
			end
		end
	end

	ppd_coord #(.RADIUS_BITS(RADIUS_BITS)) u_coord_from (
		.clk    (clk),
		.en     (pipe_en),
		.radius (rad_from_q[ANG_LAT-1]),
		.elev   (trig_fe),
		.azim   (trig_fa),
		.x      (ca[0]),
		.y      (ca[1]),
		.z      (ca[2])
	);

	ppd_coord #(.RADIUS_BITS(RADIUS_BITS)) u_coord_to (
		.clk    (clk),
		.en     (pipe_en),
		.radius (rad_to_q[ANG_LAT-1]),
		.elev   (trig_te),
		.azim   (trig_ta),
		.x      (cb[0]),
		.y      (cb[1]),
		.z      (cb[2])
	);

	always_comb begin
		for (int i = 0; i < 3; i++)
			diff[i] = $signed({ca[i][C_W-1], ca[i]}) - $signed({cb[i][C_W-1], cb[i]});
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < 3; i++) begin
				dmag_s1[i] <= diff[i][C_W] ? C_W'(-diff[i]) : C_W'(diff[i]);
				sq_s2[i]   <= SQ_W'(dmag_s1[i]) * SQ_W'(dmag_s1[i]);
			end
		end
	end

	assign sum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

	// saturate at the top of the root input range
	always_ff @(posedge clk) begin
		if (pipe_en)
			sum_s3 <= (|sum[SUM_W-1:SQ_IN_W]) ? '1 : sum[SQ_IN_W-1:0];
	end

	assign rem_c[0]  = sum_s3;
	assign root_c[0] = '0;

	for (genvar k = 0; k < SQRT_N; k++) begin : g_root
		ppd_sqrt_cell #(.IDX(SQRT_N - 1 - k)) u_cell (
			.clk      (clk),
			.en       (pipe_en),
			.rem_in   (rem_c[k]),
			.root_in  (root_c[k]),
			.rem_out  (rem_c[k+1]),
			.root_out (root_c[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pipe_en && vld_q[PIPE_LAT-1]) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en && vld_q[PIPE_LAT-1])
			sep_q <= root_c[SQRT_N][SEP_W-1:0];
	end

	assign result.valid      = out_vld_q;
	assign result.separation = sep_q;

	`PPD_ASSERT_IMPL(a_empty_out_takes, !result.valid, points.ready, "input refused with output empty")
	`PPD_ASSERT_NEXT(a_last_reaches_out, pipe_en && vld_q[PIPE_LAT-1], result.valid, "finished word lost")
	`PPD_ASSERT_NEXT(a_taken_clears, result.valid && result.ready && !vld_q[PIPE_LAT-1], !result.valid, "word repeated")
	`PPD_ASSERT_NEXT(a_accept_enters, points.valid && points.ready, vld_q[0], "accepted word not tracked")
endmodule
